// ----- hdl/binary_image_thinning_assert.svh -----
// ----------------------------------------------------------------------------
// binary_image_thinning assertion macros
// Concurrent assertion shorthands shared by the thinning block; they expand
// to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_THINNING_ASSERT_SVH
`define BINARY_IMAGE_THINNING_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BIT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// antecedent implies consequent in the next cycle
`define BIT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// condition holds on every clock
`define BIT_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

`else

`define BIT_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define BIT_ASSERT_NEXT(name, clk, rst, ante, cons)
`define BIT_ASSERT_ALWAYS(name, clk, rst, cond)

`endif

`endif

// ----- hdl/bit_pkg.sv -----
// ----------------------------------------------------------------------------
// bit_pkg
// Sizes, codes and controller/datapath interface types of the thinning block.
// ----------------------------------------------------------------------------
package bit_pkg;

   // frame geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = $clog2(CELLS);

   // field widths
   localparam int OP_W      = 2;
   localparam int PIX_W     = 8;
   localparam int PASS_W    = 16;
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 1;

   // register reset value is 256, clamped to the frame limits
   localparam int RESET_DIM  = 256;
   localparam int RESET_W_M1 = ((RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM) - 1;
   localparam int RESET_H_M1 = ((RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM) - 1;

   // pixel and neighbour constants
   localparam logic [PIX_W-1:0]  FG_VALUE = 8'd255;
   localparam logic [3:0]        MIN_NB   = 4'd2;
   localparam logic [3:0]        MAX_NB   = 4'd6;
   localparam logic [PASS_W-1:0] PASS_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'd1;

   // request operations
   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_THIN = 2'd1,
      OP_READ = 2'd2
   } op_type;

   // result kinds
   localparam logic KIND_THIN = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // 3x3 neighbourhood: [column][row], column 0 newest, row 0 bottom
   typedef logic [2:0][2:0] window_type;

   // controller to datapath
   typedef struct packed {
      logic load_wr;
      logic read_issue;
      logic scan_step;
      logic thin_start;
      logic pass_end;
      logic out_read;
      logic out_thin;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic scan_last;
      logic pipe_busy;
      logic finish;
   } dp_status_type;

endpackage

// ----- hdl/bit_decide.sv -----
// ----------------------------------------------------------------------------
// bit_decide
// Zhang-Suen deletion test for the center pixel of a 3x3 foreground window.
// ----------------------------------------------------------------------------
module bit_decide (
   input  bit_pkg::window_type window,
   input  logic                second,
   output logic                erase
);

   logic [7:0] ring;
   logic [3:0] count;
   logic [3:0] trans;
   logic       n1, n3, n5, n7;
   logic       products_ok;

   // ring of eight neighbours, clockwise from north
   always_comb begin
      ring[0] = window[1][2];
      ring[1] = window[0][2];
      ring[2] = window[0][1];
      ring[3] = window[0][0];
      ring[4] = window[1][0];
      ring[5] = window[2][0];
      ring[6] = window[2][1];
      ring[7] = window[2][2];
   end

   assign n1 = ring[0];
   assign n3 = ring[2];
   assign n5 = ring[4];
   assign n7 = ring[6];

   // neighbour count and 0-to-1 transitions around the ring
   always_comb begin
      count = '0;
      trans = '0;
      for (int k = 0; k < 8; k++) begin
         count = count + {3'd0, ring[k]};
         if (!ring[k] && ring[(k == 7) ? 0 : k + 1]) begin
            trans = trans + 4'd1;
         end
      end
   end

   // subiteration product conditions
   always_comb begin
      if (!second) begin
         products_ok = !(n3 && n5 && n7) && !(n1 && n3 && n5);
      end else begin
         products_ok = !(n1 && n5 && n7) && !(n1 && n3 && n7);
      end
   end

   assign erase = window[1][1] && (count >= bit_pkg::MIN_NB) && (count <= bit_pkg::MAX_NB)
                  && (trans == 4'd1) && products_ok;

endmodule

// ----- hdl/bit_datapath.sv -----
// ----------------------------------------------------------------------------
// bit_datapath
// Frame store, raster counters, line buffer and 3x3 window pipeline, pass
// bookkeeping and the result word register.
// ----------------------------------------------------------------------------
module bit_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  bit_pkg::dp_cmd_type                cmd,
   output bit_pkg::dp_status_type             status,
   input  logic                               csr_wr_en,
   input  logic [bit_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bit_pkg::CFG_W-1:0]          csr_wr_data,
   input  logic [bit_pkg::PIX_W-1:0]          req_pixel_in,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic                               rsp_result_kind,
   output logic [bit_pkg::PIX_W-1:0]          rsp_pixel_out,
   output logic                               rsp_last_pixel,
   output logic [bit_pkg::PASS_W-1:0]         rsp_passes_run
);

   localparam int COL_W  = bit_pkg::COL_W;
   localparam int ROW_W  = bit_pkg::ROW_W;
   localparam int ADDR_W = bit_pkg::ADDR_W;
   localparam int PIX_W  = bit_pkg::PIX_W;
   localparam int PASS_W = bit_pkg::PASS_W;

   // configuration
   logic [COL_W-1:0]  w_m1_ff, w_m1_in;
   logic [ROW_W-1:0]  h_m1_ff, h_m1_in;

   // raster counters shared by load, read and scan
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              last_px;
   logic              step;
   logic              clear;

   // memories
   logic [PIX_W-1:0]  frame_mem_ff [0:bit_pkg::CELLS-1];
   logic [PIX_W-1:0]  rd_data_ff;
   logic [1:0]        line_mem_ff [0:bit_pkg::MAX_WIDTH-1];
   logic [1:0]        lb_rd_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [PIX_W-1:0]  wr_data;

   // window pipeline
   logic                s1_valid_ff, s2_valid_ff;
   logic                s1_inner_ff, s2_inner_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic [ADDR_W-1:0]   s1_ptr_ff, s2_ptr_ff;
   bit_pkg::window_type win_ff;
   logic [2:0]          column;
   logic                erase;
   logic                del_hit;
   logic [ADDR_W-1:0]   del_addr;

   // pass bookkeeping
   logic              second_ff, second_in;
   logic              prev_empty_ff, prev_empty_in;
   logic              deleted_ff, deleted_in;
   logic [PASS_W-1:0] passes_ff, passes_in;

   // read hold and result word
   logic              last_hold_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic [PIX_W-1:0]  rsp_pixel_ff;
   logic              rsp_last_ff;
   logic [PASS_W-1:0] rsp_passes_ff;

   // register writes, values clamped to the supported frame
   always_comb begin
      w_m1_in = w_m1_ff;
      h_m1_in = h_m1_ff;
      if (csr_wr_en && csr_index == bit_pkg::CSR_WIDTH) begin
         if (csr_wr_data == '0) begin
            w_m1_in = '0;
         end else if (csr_wr_data > bit_pkg::MAX_WIDTH) begin
            w_m1_in = COL_W'(bit_pkg::MAX_WIDTH - 1);
         end else begin
            w_m1_in = COL_W'(csr_wr_data - 1'b1);
         end
      end
      if (csr_wr_en && csr_index == bit_pkg::CSR_HEIGHT) begin
         if (csr_wr_data == '0) begin
            h_m1_in = '0;
         end else if (csr_wr_data > bit_pkg::MAX_HEIGHT) begin
            h_m1_in = ROW_W'(bit_pkg::MAX_HEIGHT - 1);
         end else begin
            h_m1_in = ROW_W'(csr_wr_data - 1'b1);
         end
      end
   end

   // raster position with wrap after the frame's final pixel
   assign last_px = (col_ff == w_m1_ff) && (row_ff == h_m1_ff);
   assign step    = cmd.load_wr || cmd.read_issue || cmd.scan_step;
   assign clear   = csr_wr_en || cmd.thin_start || cmd.out_thin;

   always_comb begin
      ptr_in = ptr_ff;
      row_in = row_ff;
      col_in = col_ff;
      if (clear || (step && last_px)) begin
         ptr_in = '0;
         row_in = '0;
         col_in = '0;
      end else if (step) begin
         ptr_in = ptr_ff + 1'b1;
         if (col_ff == w_m1_ff) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // frame store write port: loads, or deletions during a scan
   always_comb begin
      wr_en   = cmd.load_wr || del_hit;
      wr_addr = cmd.load_wr ? ptr_ff : del_addr;
      wr_data = cmd.load_wr ? req_pixel_in : '0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= frame_mem_ff[ptr_ff];
   end

   // line buffer: {row above previous, previous row} foreground bits per column
   assign column = {lb_rd_ff[1], lb_rd_ff[0], rd_data_ff == bit_pkg::FG_VALUE};

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem_ff[s1_col_ff] <= {lb_rd_ff[0], column[0]};
      end
      lb_rd_ff <= line_mem_ff[col_ff];
   end

   // window pipeline, payload part
   always_ff @(posedge clock) begin
      s1_col_ff   <= col_ff;
      s1_ptr_ff   <= ptr_ff;
      s1_inner_ff <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      s2_ptr_ff   <= s1_ptr_ff;
      s2_inner_ff <= s1_inner_ff;
      if (s1_valid_ff) begin
         win_ff[2] <= win_ff[1];
         win_ff[1] <= win_ff[0];
         win_ff[0] <= column;
      end
   end

   bit_decide u_decide (
      .window (win_ff),
      .second (second_ff),
      .erase  (erase)
   );

   // center pixel sits one row and one column behind the newest pixel
   assign del_hit  = s2_valid_ff && s2_inner_ff && erase;
   assign del_addr = s2_ptr_ff - ADDR_W'(w_m1_ff) - ADDR_W'(2);

   // pass bookkeeping
   always_comb begin
      second_in     = second_ff;
      prev_empty_in = prev_empty_ff;
      deleted_in    = deleted_ff || del_hit;
      passes_in     = passes_ff;
      if (cmd.thin_start) begin
         second_in     = 1'b0;
         prev_empty_in = 1'b0;
         deleted_in    = 1'b0;
         passes_in     = '0;
      end else if (cmd.pass_end) begin
         second_in     = !second_ff;
         prev_empty_in = !deleted_ff;
         deleted_in    = 1'b0;
         if (passes_ff != bit_pkg::PASS_MAX) begin
            passes_in = passes_ff + 1'b1;
         end
      end
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_read || cmd.out_thin) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue) begin
         last_hold_ff <= last_px;
      end
      if (cmd.out_read) begin
         rsp_kind_ff   <= bit_pkg::KIND_READ;
         rsp_pixel_ff  <= rd_data_ff;
         rsp_last_ff   <= last_hold_ff;
         rsp_passes_ff <= '0;
      end else if (cmd.out_thin) begin
         rsp_kind_ff   <= bit_pkg::KIND_THIN;
         rsp_pixel_ff  <= '0;
         rsp_last_ff   <= 1'b0;
         rsp_passes_ff <= passes_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         w_m1_ff       <= COL_W'(bit_pkg::RESET_W_M1);
         h_m1_ff       <= ROW_W'(bit_pkg::RESET_H_M1);
         ptr_ff        <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         second_ff     <= 1'b0;
         prev_empty_ff <= 1'b0;
         deleted_ff    <= 1'b0;
         passes_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         w_m1_ff       <= w_m1_in;
         h_m1_ff       <= h_m1_in;
         ptr_ff        <= ptr_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         s1_valid_ff   <= cmd.scan_step;
         s2_valid_ff   <= s1_valid_ff;
         second_ff     <= second_in;
         prev_empty_ff <= prev_empty_in;
         deleted_ff    <= deleted_in;
         passes_ff     <= passes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // status to the controller
   always_comb begin
      status.out_free  = !rsp_valid_ff || !rsp_stall;
      status.scan_last = last_px;
      status.pipe_busy = s1_valid_ff || s2_valid_ff;
      status.finish    = prev_empty_ff && !deleted_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_last_pixel  = rsp_last_ff;
   assign rsp_passes_run  = rsp_passes_ff;

endmodule

// ----- hdl/bit_ctrl.sv -----
// ----------------------------------------------------------------------------
// bit_ctrl
// Sequencer for load, read and thin requests; drives datapath commands.
// ----------------------------------------------------------------------------
module bit_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [bit_pkg::OP_W-1:0]     req_operation,
   output logic                         req_stall,
   input  bit_pkg::dp_status_type       status,
   output bit_pkg::dp_cmd_type          cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_PASS  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      wants_out;

   // reads and thin runs need a free result slot
   assign wants_out = (req_operation == bit_pkg::OP_THIN) ||
                      (req_operation == bit_pkg::OP_READ);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = wants_out && !status.out_free;
            if (req_valid && !req_stall) begin
               case (req_operation)
                  bit_pkg::OP_LOAD: begin
                     cmd.load_wr = 1'b1;
                  end
                  bit_pkg::OP_THIN: begin
                     cmd.thin_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  bit_pkg::OP_READ: begin
                     cmd.read_issue = 1'b1;
                     state_in       = ST_READ;
                  end
                  default: begin
                     // unused operation code is dropped
                  end
               endcase
            end
         end
         // frame store data is out, move it to the result word
         ST_READ: begin
            cmd.out_read = 1'b1;
            state_in     = ST_IDLE;
         end
         // one pixel per cycle through the window pipeline
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // let the last deletions reach the frame store
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_PASS;
            end
         end
         // close the subiteration
         ST_PASS: begin
            cmd.pass_end = 1'b1;
            state_in     = status.finish ? ST_DONE : ST_SCAN;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_thin = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/binary_image_thinning.sv -----
// ----------------------------------------------------------------------------
// binary_image_thinning
// Zhang-Suen thinning of an 8-bit frame of up to 256 x 256 pixels held in an
// on-chip frame store. A load word writes the next pixel in raster order; a
// read word passes the frame store read, then the result register, and
// returns the next pixel with a last-pixel flag. A thin word scans the whole
// frame once per subiteration through a two-row line buffer and a 3x3 window,
// one pixel per cycle, limited by the single frame store read port; the run
// ends after two subiterations in a row delete nothing. Only pixels equal to
// 255 are foreground; deleted pixels become 0 and all other values are left
// as loaded. Register writes reset the raster position to the first pixel,
// and so does a finished thin run.
// ----------------------------------------------------------------------------
`include "binary_image_thinning_assert.svh"

module binary_image_thinning (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bit_pkg::OP_W-1:0]          req_operation,
   input  logic [bit_pkg::PIX_W-1:0]         req_pixel_in,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_result_kind,
   output logic [bit_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic                              rsp_last_pixel,
   output logic [bit_pkg::PASS_W-1:0]        rsp_passes_run,
   // register write port
   input  logic                              csr_wr_en,
   input  logic [bit_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bit_pkg::CFG_W-1:0]         csr_wr_data
);

   bit_pkg::dp_cmd_type    cmd;
   bit_pkg::dp_status_type status;

   // sequencer
   bit_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // frame store and window pipeline
   bit_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_pixel_in    (req_pixel_in),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_last_pixel  (rsp_last_pixel),
      .rsp_passes_run  (rsp_passes_run)
   );

   // read data lands in an empty result register
   `BIT_ASSERT_IMPLY(a_read_slot_empty, clock, reset, cmd.out_read, !rsp_valid)

   // a thin run reports at least two subiterations
   `BIT_ASSERT_NEXT(a_thin_min_passes, clock, reset, cmd.out_thin, rsp_valid && (rsp_passes_run > 16'd1))

   // no request is taken while the window pipeline holds pixels
   `BIT_ASSERT_IMPLY(a_scan_blocks_req, clock, reset, cmd.scan_step || status.pipe_busy, req_stall)

   // frame store address users never collide
   `BIT_ASSERT_ALWAYS(a_cmd_exclusive, clock, reset, $onehot0({cmd.load_wr, cmd.read_issue, cmd.scan_step, cmd.thin_start, cmd.pass_end}))

endmodule

// ----- tb/sv/binary_image_thinning_test.sv -----
// ----------------------------------------------------------------------------
// binary_image_thinning_test
// Self-checking bench for the frame thinning block. Words go in on the request
// channel with random bursts and gaps, results are taken with a randomly
// stalling receiver, and every result is checked against an in-bench model of
// the frame store, the raster position and the two-subiteration thinning loop.
// Directed tests cover pointer wrap, register clamping, small frames, ignored
// operations and a long receiver hold-off. Random phases follow, each with its
// own frame size and picture.
// ----------------------------------------------------------------------------
module binary_image_thinning_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_W      = bit_pkg::OP_W;
   localparam int PIX_W     = bit_pkg::PIX_W;
   localparam int PASS_W    = bit_pkg::PASS_W;
   localparam int CFG_W     = bit_pkg::CFG_W;
   localparam int CSR_IDX_W = bit_pkg::CSR_IDX_W;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS  = 250;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 250;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic              kind;
      logic [PIX_W-1:0]  pixel;
      logic              last;
      logic [PASS_W-1:0] passes;
   } rsp_word_type;

   typedef enum {SHAPE_NOISE, SHAPE_BLOCKS, SHAPE_GREY} shape_kind_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_W-1:0]      req_operation;
   logic [PIX_W-1:0]     req_pixel_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_result_kind;
   logic [PIX_W-1:0]     rsp_pixel_out;
   logic                 rsp_last_pixel;
   logic [PASS_W-1:0]    rsp_passes_run;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wr_data;

   // model state of the block
   logic [PIX_W-1:0] frame_img [bit_pkg::CELLS];
   bit               pix_written [bit_pkg::CELLS];
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   int unsigned      raster_pos;
   int unsigned      unwritten_cells;
   rsp_word_type     awaited_results[$];

   // bench bookkeeping
   int             mismatches;
   int             words_sent;
   int             burst_left;
   bit             hold_request;
   shape_kind_type shape_style;
   int unsigned    fill_pct;
   int unsigned    block_count;
   int unsigned    blk_r0 [3];
   int unsigned    blk_r1 [3];
   int unsigned    blk_c0 [3];
   int unsigned    blk_c1 [3];

   binary_image_thinning dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_last_pixel  (rsp_last_pixel),
      .rsp_passes_run  (rsp_passes_run),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // frame model
   // ---------------------------------------------------------------------

   // out-of-range sizes clamp to 1 and to the frame limits
   function automatic int unsigned cols_used();
      if (width_reg == 0) return 1;
      if (width_reg > bit_pkg::MAX_WIDTH) return bit_pkg::MAX_WIDTH;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned rows_used();
      if (height_reg == 0) return 1;
      if (height_reg > bit_pkg::MAX_HEIGHT) return bit_pkg::MAX_HEIGHT;
      return 32'(height_reg);
   endfunction

   function automatic int unsigned frame_cells();
      return cols_used() * rows_used();
   endfunction

   function automatic bit is_fg(input int unsigned p);
      return frame_img[p] == bit_pkg::FG_VALUE;
   endfunction

   // queue one expected result word
   function automatic void expect_result(input rsp_word_type res);
      awaited_results = {awaited_results, res};
   endfunction

   // one subiteration over the snapshot; deletions land after the scan
   function automatic int unsigned run_subpass(input bit second);
      int unsigned w, h, p, cnt, trans, k;
      bit [8:1]    nb;
      bit          nx;
      int unsigned doomed[$];
      w = cols_used();
      h = rows_used();
      for (int unsigned r = 1; r + 1 < h; r++) begin
         for (int unsigned c = 1; c + 1 < w; c++) begin
            p = r * w + c;
            if (frame_img[p] != bit_pkg::FG_VALUE) continue;
            // ring starts north and runs clockwise
            nb[1] = is_fg(p - w);
            nb[2] = is_fg(p - w + 1);
            nb[3] = is_fg(p + 1);
            nb[4] = is_fg(p + w + 1);
            nb[5] = is_fg(p + w);
            nb[6] = is_fg(p + w - 1);
            nb[7] = is_fg(p - 1);
            nb[8] = is_fg(p - w - 1);
            cnt = 0;
            trans = 0;
            for (k = 1; k <= 8; k++) begin
               nx = (k == 8) ? nb[1] : nb[k + 1];
               cnt += 32'(nb[k]);
               if (!nb[k] && nx) trans++;
            end
            if (cnt < bit_pkg::MIN_NB || cnt > bit_pkg::MAX_NB || trans != 1) continue;
            if (!second) begin
               if ((nb[3] & nb[5] & nb[7]) | (nb[1] & nb[3] & nb[5])) continue;
            end else begin
               if ((nb[1] & nb[5] & nb[7]) | (nb[1] & nb[3] & nb[7])) continue;
            end
            doomed = {doomed, p};
         end
      end
      foreach (doomed[i]) frame_img[doomed[i]] = '0;
      return doomed.size();
   endfunction

   // alternate subiterations until two in a row delete nothing
   function automatic logic [PASS_W-1:0] thin_frame();
      int unsigned passes;
      int unsigned empties;
      bit          second;
      passes = 0;
      empties = 0;
      second = 1'b0;
      while (empties < 2) begin
         if (run_subpass(second) == 0) empties++;
         else empties = 0;
         second = !second;
         if (passes < bit_pkg::PASS_MAX) passes++;
      end
      raster_pos = 0;
      return passes[PASS_W-1:0];
   endfunction

   // update the model for one accepted word and queue its result
   function automatic void predict_word(input logic [OP_W-1:0] op,
                                        input logic [PIX_W-1:0] pix);
      int unsigned  total, p;
      rsp_word_type res;
      total = frame_cells();
      p = (raster_pos < total) ? raster_pos : 0;
      case (op)
         bit_pkg::OP_LOAD: begin
            frame_img[p] = pix;
            if (!pix_written[p]) begin
               pix_written[p] = 1'b1;
               unwritten_cells--;
            end
            raster_pos = (p + 1 >= total) ? 0 : p + 1;
         end
         bit_pkg::OP_THIN: begin
            res.kind   = bit_pkg::KIND_THIN;
            res.pixel  = '0;
            res.last   = 1'b0;
            res.passes = thin_frame();
            expect_result(res);
         end
         bit_pkg::OP_READ: begin
            res.kind   = bit_pkg::KIND_READ;
            res.pixel  = frame_img[p];
            res.last   = (p + 1 >= total);
            res.passes = '0;
            expect_result(res);
            raster_pos = (p + 1 >= total) ? 0 : p + 1;
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // picture generator
   // ---------------------------------------------------------------------

   function automatic void choose_shape(input int unsigned w, input int unsigned h);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      shape_style = (roll < 5) ? SHAPE_BLOCKS : (roll < 8) ? SHAPE_NOISE : SHAPE_GREY;
      fill_pct = $urandom_range(30, 95);
      block_count = $urandom_range(1, 3);
      for (int i = 0; i < 3; i++) begin
         blk_r0[i] = $urandom_range(0, h - 1);
         blk_r1[i] = $urandom_range(blk_r0[i], h - 1);
         blk_c0[i] = $urandom_range(0, w - 1);
         blk_c1[i] = $urandom_range(blk_c0[i], w - 1);
      end
   endfunction

   function automatic logic [PIX_W-1:0] shape_pixel(input int unsigned r,
                                                    input int unsigned c);
      bit in_block;
      in_block = 1'b0;
      case (shape_style)
         SHAPE_NOISE: return ($urandom_range(0, 99) < fill_pct) ? bit_pkg::FG_VALUE : '0;
         SHAPE_GREY:  return ($urandom_range(0, 3) == 0) ? bit_pkg::FG_VALUE
                                                         : PIX_W'($urandom_range(0, 255));
         default: begin
            for (int i = 0; i < block_count; i++)
               if (r >= blk_r0[i] && r <= blk_r1[i] && c >= blk_c0[i] && c <= blk_c1[i])
                  in_block = 1'b1;
            // stray grey values anywhere, holes inside the blocks
            if ($urandom_range(0, 24) == 0) return PIX_W'($urandom_range(0, 255));
            if (in_block && $urandom_range(0, 29) == 0) return '0;
            return in_block ? bit_pkg::FG_VALUE : '0;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // offer one word in bursts with random gaps; called at a falling edge
   task automatic send_word(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix);
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_valid     = 1'b1;
      req_operation = op;
      req_pixel_in  = pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(op, pix);
      if (op != OP_UNUSED) words_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // no word offered, every result back, loads given time to land
   task automatic wait_idle();
      req_valid = 1'b0;
      burst_left = 0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == bit_pkg::CSR_WIDTH) width_reg = data;
      else height_reg = data;
      raster_pos = 0;
   endtask

   task automatic set_frame_size(input logic [CFG_W-1:0] w_val,
                                 input logic [CFG_W-1:0] h_val);
      int unsigned total;
      wait_idle();
      write_register(bit_pkg::CSR_WIDTH, w_val);
      write_register(bit_pkg::CSR_HEIGHT, h_val);
      total = frame_cells();
      unwritten_cells = 0;
      for (int unsigned p = 0; p < total; p++)
         if (!pix_written[p]) unwritten_cells++;
   endtask

   // whole frame from the current picture, starting at the first pixel
   task automatic load_frame();
      int unsigned w, total;
      w = cols_used();
      total = frame_cells();
      for (int unsigned p = 0; p < total; p++)
         send_word(bit_pkg::OP_LOAD, shape_pixel(p / w, p % w));
   endtask

   task automatic read_words(input int n);
      repeat (n) send_word(bit_pkg::OP_READ, PIX_W'($urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // pixel extremes through the store, read past the last pixel
   task automatic test_load_read_wrap();
      logic [PIX_W-1:0] vals [12];
      vals = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127,
               8'h55, 8'hAA, 8'd255, 8'd255, 8'd64, 8'd255};
      set_frame_size(4, 3);
      foreach (vals[i]) send_word(bit_pkg::OP_LOAD, vals[i]);
      read_words(13);
      // loads wrap as well
      repeat (12) send_word(bit_pkg::OP_LOAD, PIX_W'($urandom_range(0, 255)));
      read_words(2);
   endtask

   task automatic test_ignored_operation();
      send_word(OP_UNUSED, 8'hFF);
      send_word(OP_UNUSED, 8'h00);
      read_words(2);
   endtask

   // a register write rewinds the raster position
   task automatic test_register_rewind();
      read_words(3);
      set_frame_size(4, 3);
      read_words(2);
   endtask

   // zero and oversized registers clamp; single-row and single-column frames
   task automatic test_size_clamp();
      choose_shape(1, 7);
      set_frame_size(0, 7);
      load_frame();
      send_word(bit_pkg::OP_THIN, 8'd0);
      read_words(8);
      choose_shape(256, 1);
      set_frame_size(511, 0);
      load_frame();
      // loads wrapped only after the clamped width
      read_words(3);
      send_word(bit_pkg::OP_THIN, 8'd0);
      read_words(2);
   endtask

   // frames under three rows or columns have nothing to delete
   task automatic test_small_frame();
      set_frame_size(2, 5);
      choose_shape(2, 5);
      load_frame();
      send_word(bit_pkg::OP_THIN, 8'd0);
      set_frame_size(5, 2);
      load_frame();
      send_word(bit_pkg::OP_THIN, 8'd0);
      read_words(4);
   endtask

   // solid block thinned; the run rewinds the raster position
   task automatic test_thin_block();
      set_frame_size(7, 6);
      shape_style = SHAPE_BLOCKS;
      block_count = 1;
      blk_r0[0] = 1;
      blk_r1[0] = 4;
      blk_c0[0] = 1;
      blk_c1[0] = 5;
      load_frame();
      read_words(3);
      send_word(bit_pkg::OP_THIN, 8'd0);
      read_words(42);
      // an already thin frame takes two empty subiterations
      send_word(bit_pkg::OP_THIN, 8'd0);
      read_words(5);
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_backpressure();
      set_frame_size(6, 6);
      choose_shape(6, 6);
      load_frame();
      hold_request = 1'b1;
      read_words(30);
      send_word(bit_pkg::OP_THIN, 8'd0);
      read_words(10);
   endtask

   // random frame sizes and pictures with a random mix of words
   task automatic test_random_mix();
      int          start, n, roll;
      int unsigned w, h, total;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         roll = $urandom_range(0, 19);
         if (roll < 14) begin
            w = $urandom_range(3, 10);
            h = $urandom_range(3, 10);
         end else if (roll < 17) begin
            w = $urandom_range(1, 2);
            h = $urandom_range(1, 12);
            if (roll == 16) begin
               w = h;
               h = $urandom_range(1, 2);
            end
         end else begin
            w = $urandom_range(10, 16);
            h = $urandom_range(10, 14);
         end
         set_frame_size(CFG_W'(w), CFG_W'(h));
         choose_shape(w, h);
         load_frame();
         if ($urandom_range(0, 9) < 7)
            send_word(bit_pkg::OP_THIN, PIX_W'($urandom_range(0, 255)));
         total = frame_cells();
         n = $urandom_range(4, 40);
         repeat (n) begin
            roll = $urandom_range(0, 99);
            if (unwritten_cells != 0) roll = 60;
            if (roll < 8) send_word(bit_pkg::OP_THIN, PIX_W'($urandom_range(0, 255)));
            else if (roll < 50) send_word(bit_pkg::OP_READ, PIX_W'($urandom_range(0, 255)));
            else if (roll < 80)
               send_word(bit_pkg::OP_LOAD, shape_pixel(raster_pos / w, raster_pos % w));
            else if (roll < 85) send_word(OP_UNUSED, PIX_W'($urandom_range(0, 255)));
            else begin
               if ($urandom_range(0, 4) == 0) hold_request = 1'b1;
               read_words((total <= 200) ? total : 50);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver: stretches of differing stall patterns, plus long hold-offs
   // ---------------------------------------------------------------------
   initial begin : receiver
      int stretch;
      int mode;
      rsp_stall = 1'b0;
      forever begin
         stretch = $urandom_range(10, 150);
         mode = $urandom_range(0, 3);
         repeat (stretch) begin
            @(negedge clock);
            if (hold_request) begin
               rsp_stall = 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_request = 1'b0;
            end
            case (mode)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = ($urandom_range(0, 3) == 0);
               2:       rsp_stall = ($urandom_range(0, 9) < 7);
               default: rsp_stall = ~rsp_stall;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // result check against the oldest expected word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("%0t: unexpected result word kind %0d pixel %0d last %0d passes %0d",
                        $time, rsp_result_kind, rsp_pixel_out, rsp_last_pixel,
                        rsp_passes_run);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_result_kind !== want.kind || rsp_pixel_out !== want.pixel ||
                rsp_last_pixel !== want.last || rsp_passes_run !== want.passes) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("%0t: result mismatch, expected kind %0d pixel %0d last %0d passes %0d",
                           $time, want.kind, want.pixel, want.last, want.passes);
                  $display("   got kind %0d pixel %0d last %0d passes %0d",
                           rsp_result_kind, rsp_pixel_out, rsp_last_pixel, rsp_passes_run);
               end
               mismatches++;
            end
         end
      end
   end

   // run limit
   initial begin : watchdog
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : main
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = bit_pkg::OP_LOAD;
      req_pixel_in  = '0;
      csr_wr_en     = 1'b0;
      csr_index     = bit_pkg::CSR_WIDTH;
      csr_wr_data   = '0;
      hold_request  = 1'b0;
      mismatches    = 0;
      words_sent    = 0;
      burst_left    = 0;
      width_reg     = CFG_W'(bit_pkg::RESET_DIM);
      height_reg    = CFG_W'(bit_pkg::RESET_DIM);
      raster_pos    = 0;
      unwritten_cells = bit_pkg::CELLS;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_load_read_wrap();
      test_ignored_operation();
      test_register_rewind();
      test_size_clamp();
      test_small_frame();
      test_thin_block();
      test_backpressure();
      test_random_mix();

      wait_idle();
      if (mismatches == 0 && awaited_results.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/bit_pkg.sv
hdl/bit_decide.sv
hdl/bit_datapath.sv
hdl/bit_ctrl.sv
hdl/binary_image_thinning.sv
tb/sv/binary_image_thinning_test.sv
